// ===== sv/tcmk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcmk_pkg
// Shared types, constants and helpers of the triangle centroid Morton key core.
// ----------------------------------------------------------------------------
package tcmk_pkg;

  // Field widths.
  localparam int COORD_W = 32;           // Q16.16 vertex coordinate
  localparam int TAG_W   = 32;
  localparam int KEY_W   = 30;
  localparam int INV_W   = 32;           // Q8.24 reciprocal extent
  localparam int SUM_W   = COORD_W + 2;  // sum of three coordinates
  localparam int DIFF_W  = SUM_W + 1;    // sum minus three times the minimum
  localparam int AXES    = 3;
  localparam int VERTS   = 3;

  // Stream widths.
  localparam int IN_DATA_W  = TAG_W + AXES * VERTS * COORD_W;
  localparam int OUT_DATA_W = ((KEY_W + TAG_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EXTENT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EXTENT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EXTENT_Z = 3'd5;
  localparam logic [INV_W-1:0]     INV_ONE          = 32'h0100_0000;

  // Scale: the product d * inv is in units of 2^-40 / 3, so 1.0 is 3 * 2^40.
  localparam int FULL_W = 42;
  localparam logic [FULL_W-1:0] FULL_SCALE = 42'h300_0000_0000;
  localparam logic [FULL_W-1:0] HALF_SCALE = 42'h180_0000_0000;
  localparam int FRAC_SH = 40;

  // Partial products of the 34 x 32 bit multiply.
  localparam int SPLIT_W = 17;
  localparam int PART_W  = SPLIT_W + INV_W;
  localparam int PROD_W  = SUM_W + INV_W;

  // Divide by three through a reciprocal: exact for dividends below 2^25.
  localparam int DIV3_W = 24;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 24'hAA_AAAB;
  localparam int DIV3_SH = 25;

  // Pipeline depth of one lane.
  localparam int LANE_STAGES = 6;

  localparam int AXIS_BITS_DEF = 10;

  typedef struct packed {
    logic signed [SUM_W-1:0] min3;  // three times the box minimum
    logic [INV_W-1:0]        inv;
  } axis_cfg_t;

  function automatic logic [SUM_W-1:0] times3(input logic [COORD_W-1:0] v);
    logic [SUM_W-1:0] ext;
    ext = {{2{v[COORD_W-1]}}, v};
    return ext + {ext[SUM_W-2:0], 1'b0};
  endfunction

endpackage : tcmk_pkg
`default_nettype wire

// ===== sv/triangle_centroid_morton_key_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_centroid_morton_key_core
// Turns one triangle per beat into a 30-bit Morton key of its centroid.
// ----------------------------------------------------------------------------
// Each input beat carries a tag and three vertices in signed Q16.16. Three
// identical lanes, one per axis, sum the vertices, subtract three times the
// configured box minimum, multiply by the configured reciprocal extent
// (unsigned Q8.24), clamp the result to 0..1, scale it by 2^AXIS_BITS - 1 and
// round half up; a final stage interleaves the three axes into the key (x in
// bit 0) and keeps it with the tag in the output register. The lanes are fully
// pipelined, so the core takes one triangle every cycle unless the output
// stalls; an accepted triangle passes through the six lane stages and then
// loads the output register. Each pipeline stage stalls only when it is full
// and the stage after it cannot move, so bubbles are squeezed out and input
// beats are still taken while a finished key waits at the output. The user
// must write the registers over the configuration port only while no triangle
// is in flight; the block does not enforce it. cfg_ready is always high and
// writes to indexes above five are dropped.
// ----------------------------------------------------------------------------
module triangle_centroid_morton_key_core #(
  parameter int AXIS_BITS = tcmk_pkg::AXIS_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // From bit 0: tri_tag, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 each).
  input  wire logic [tcmk_pkg::IN_DATA_W-1:0]      in_tdata,
  // Output stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // From bit 0: morton_key (30), tag_out (32), two zero bits.
  output logic [tcmk_pkg::OUT_DATA_W-1:0]          out_tdata,
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tcmk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tcmk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcmk_pkg::*;

  localparam int LAST = LANE_STAGES - 1;

  // Per-axis configuration, with the minimum stored already multiplied by three.
  axis_cfg_t cfg_r [AXES];

  logic [LANE_STAGES-1:0] v_r, v_nxt;
  logic [LANE_STAGES-1:0] stage_en;
  logic [LANE_STAGES:0]   rdy;
  logic [TAG_W-1:0]       tag_r [LANE_STAGES];
  logic [AXIS_BITS-1:0]   q [AXES];
  logic                   merge_ready;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        cfg_r[i].min3 <= '0;
        cfg_r[i].inv  <= INV_ONE;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOX_MIN_X:    cfg_r[0].min3 <= times3(cfg_data);
        REG_BOX_MIN_Y:    cfg_r[1].min3 <= times3(cfg_data);
        REG_BOX_MIN_Z:    cfg_r[2].min3 <= times3(cfg_data);
        REG_INV_EXTENT_X: cfg_r[0].inv  <= cfg_data;
        REG_INV_EXTENT_Y: cfg_r[1].inv  <= cfg_data;
        REG_INV_EXTENT_Z: cfg_r[2].inv  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. A stage can take a new beat when it is empty or when
  // its own beat moves on in the same cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    rdy[LANE_STAGES] = merge_ready;
    for (int k = LANE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < LANE_STAGES; k++) begin
      if (k == 0) begin
        stage_en[k] = rdy[k] && in_tvalid;
      end else begin
        stage_en[k] = rdy[k] && v_r[k-1];
      end
      v_nxt[k] = stage_en[k] || (v_r[k] && !rdy[k+1]);
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // The tag travels beside the lanes.
  always_ff @(posedge clk) begin
    for (int k = 0; k < LANE_STAGES; k++) begin
      if (stage_en[k]) begin
        if (k == 0) begin
          tag_r[k] <= in_tdata[TAG_W-1:0];
        end else begin
          tag_r[k] <= tag_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // One lane per axis. Vertex v, axis j sits at field 1 + 3v + j.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < AXES; j++) begin : g_lane
    tcmk_lane #(
      .AXIS_BITS (AXIS_BITS)
    ) u_lane (
      .clk      (clk),
      .stage_en (stage_en),
      .cfg      (cfg_r[j]),
      .a        (in_tdata[TAG_W + (0 * AXES + j) * COORD_W +: COORD_W]),
      .b        (in_tdata[TAG_W + (1 * AXES + j) * COORD_W +: COORD_W]),
      .c        (in_tdata[TAG_W + (2 * AXES + j) * COORD_W +: COORD_W]),
      .q        (q[j])
    );
  end

  // --------------------------------------------------------------------------
  // Key interleave and output register.
  // --------------------------------------------------------------------------
  tcmk_merge #(
    .AXIS_BITS (AXIS_BITS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v_r[LAST]),
    .in_ready   (merge_ready),
    .q_x        (q[0]),
    .q_y        (q[1]),
    .q_z        (q[2]),
    .tag        (tag_r[LAST]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // An accepted input beat occupies the first stage in the next cycle.
  a_accept_fills_stage0 : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat did not enter the first stage");

  // A finished beat blocked by the output register keeps its place and tag.
  a_last_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !merge_ready |=> v_r[LAST] && $stable(tag_r[LAST]))
    else $error("stalled beat in the last stage was lost");

  // The output empties when its beat is taken and nothing follows.
  a_no_invented_beat : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !v_r[LAST] |=> !out_tvalid)
    else $error("output beat appeared without a source");

endmodule : triangle_centroid_morton_key_core
`default_nettype wire

// ===== sv/tcmk_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcmk_lane
// One axis: centroid sum, offset, reciprocal multiply, clamp, scale and round.
// ----------------------------------------------------------------------------
module tcmk_lane #(
  parameter int AXIS_BITS = tcmk_pkg::AXIS_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic [tcmk_pkg::LANE_STAGES-1:0]     stage_en,
  input  wire tcmk_pkg::axis_cfg_t                  cfg,
  input  wire logic signed [tcmk_pkg::COORD_W-1:0]  a,
  input  wire logic signed [tcmk_pkg::COORD_W-1:0]  b,
  input  wire logic signed [tcmk_pkg::COORD_W-1:0]  c,
  output logic [AXIS_BITS-1:0]                      q
);
  import tcmk_pkg::*;

  localparam logic [AXIS_BITS-1:0] MAXQ = {AXIS_BITS{1'b1}};
  localparam int NW = FULL_W + AXIS_BITS;
  localparam int MW = AXIS_BITS + 2;
  localparam int RW = MW + DIV3_W;

  // Stage 1: sum of the three vertices.
  logic signed [SUM_W-1:0] sum_r;
  // Stage 2: offset from the box minimum.
  logic [SUM_W-1:0] d_r;
  logic             zero2_r;
  // Stage 3: partial products.
  logic [PART_W-1:0] ph_r, pl_r;
  logic              zero3_r;
  // Stage 4: clamped product.
  logic [FULL_W-1:0] pc_r;
  // Stage 5: scaled value, still three times too large.
  logic [MW-1:0] m_r;
  // Stage 6: quantized axis.
  logic [AXIS_BITS-1:0] q_r;

  logic signed [DIFF_W-1:0] diff;
  logic [PROD_W-1:0]        prod;
  logic [FULL_W-1:0]        pc_nxt;
  logic [NW-1:0]            scaled;
  logic [RW-1:0]            recip;

  assign diff   = {sum_r[SUM_W-1], sum_r} - {cfg.min3[SUM_W-1], cfg.min3};
  assign prod   = {ph_r, {SPLIT_W{1'b0}}} + PROD_W'(pl_r);
  assign scaled = NW'(pc_r) * NW'(MAXQ) + NW'(HALF_SCALE);
  assign recip  = RW'(m_r) * RW'(DIV3_MUL);

  always_comb begin
    if (zero3_r) begin
      pc_nxt = '0;
    end else if (prod > PROD_W'(FULL_SCALE)) begin
      pc_nxt = FULL_SCALE;
    end else begin
      pc_nxt = prod[FULL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sum_r <= {{2{a[COORD_W-1]}}, a} + {{2{b[COORD_W-1]}}, b} + {{2{c[COORD_W-1]}}, c};
    end
    if (stage_en[1]) begin
      // A centroid at or below the minimum, or a zero reciprocal, gives zero.
      d_r     <= diff[SUM_W-1:0];
      zero2_r <= diff[DIFF_W-1] || (diff == '0) || (cfg.inv == '0);
    end
    if (stage_en[2]) begin
      ph_r    <= PART_W'(d_r[SUM_W-1:SPLIT_W]) * PART_W'(cfg.inv);
      pl_r    <= PART_W'(d_r[SPLIT_W-1:0]) * PART_W'(cfg.inv);
      zero3_r <= zero2_r;
    end
    if (stage_en[3]) begin
      pc_r <= pc_nxt;
    end
    if (stage_en[4]) begin
      m_r <= scaled[NW-1:FRAC_SH];
    end
    if (stage_en[5]) begin
      q_r <= recip[DIV3_SH +: AXIS_BITS];
    end
  end

  assign q = q_r;

endmodule : tcmk_lane
`default_nettype wire

// ===== sv/tcmk_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcmk_merge
// Interleaves the three quantized axes into the key and holds the output beat.
// ----------------------------------------------------------------------------
module tcmk_merge #(
  parameter int AXIS_BITS = tcmk_pkg::AXIS_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [AXIS_BITS-1:0]                q_x,
  input  wire logic [AXIS_BITS-1:0]                q_y,
  input  wire logic [AXIS_BITS-1:0]                q_z,
  input  wire logic [tcmk_pkg::TAG_W-1:0]          tag,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tcmk_pkg::OUT_DATA_W-1:0]          out_tdata
);
  import tcmk_pkg::*;

  localparam int KFW = (3 * AXIS_BITS > KEY_W) ? 3 * AXIS_BITS : KEY_W;

  logic                  valid_r, valid_nxt;
  logic [KEY_W-1:0]      key_r;
  logic [TAG_W-1:0]      tag_r;
  logic [KFW-1:0]        key_full;
  logic                  load;

  always_comb begin
    key_full = '0;
    for (int i = 0; i < AXIS_BITS; i++) begin
      key_full[3*i]     = q_x[i];
      key_full[3*i + 1] = q_y[i];
      key_full[3*i + 2] = q_z[i];
    end
  end

  assign in_ready = !valid_r || out_tready;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= key_full[KEY_W-1:0];
      tag_r <= tag;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_DATA_W'({tag_r, key_r});

endmodule : tcmk_merge
`default_nettype wire
